// ===== hw/rtl/lps_pkg.sv =====
// Shared types, constants and helper functions of the learned preheat scheduler.
// Used by the channel interfaces and by every module of the block.
// No dependencies.
package lps_pkg;

  localparam int SLOT_COUNT = 96;
  localparam int COUNT_BITS = 16;
  localparam int DAY_MIN = 1440;
  localparam int SLOT_W = DAY_MIN / SLOT_COUNT;
  localparam int SLOT_BITS = $clog2(SLOT_COUNT);
  localparam int MIN_BITS = 11;
  localparam int DAY_BITS = 9;
  localparam int LAST_DAY_BITS = 10;
  localparam int TEMP_BITS = 12;
  localparam int TOTAL_BITS = 16;

  // Division by the slot width as a multiply by a rounded-up reciprocal.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_BITS = RECIP_SHIFT + 1;
  localparam int SLOT_RECIP = (1 << RECIP_SHIFT) / SLOT_W + 1;
  localparam int PROD_BITS = MIN_BITS + RECIP_BITS;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [TOTAL_BITS-1:0] SAT16 = 16'hFFFF;
  localparam logic [LAST_DAY_BITS-1:0] NO_DAY = 10'h3FF;
  localparam logic signed [TEMP_BITS-1:0] HOT_LIMIT = 12'sd800;

  localparam int LEAD_BITS = 7;
  localparam int LEAD_BASE = 45;
  localparam int LEAD_STEP = 5;
  localparam int LEAD_MAX = 90;
  localparam int LEAD_FREE_SIZE = 2;
  localparam int LEAD_CAP_SIZE = LEAD_FREE_SIZE + (LEAD_MAX - LEAD_BASE) / LEAD_STEP;
  localparam int GRACE_MIN = 45;
  localparam int REL_COUNT = 3;
  localparam int REL_DAYS = 7;

  localparam int TARGETS = 4;
  localparam int TGT_BITS = $clog2(TARGETS);
  localparam int TCNT_BITS = 3;

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 11;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOUSEHOLD = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TCOUNT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TGT_A = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TGT_B = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_TGT_C = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_TGT_D = 3'd6;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_READY_BY = 2'd1;
  localparam logic [1:0] MODE_SMART = 2'd2;

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_DECIDE = 1'b1;

  typedef struct packed {
    logic [1:0] operating_mode;
    logic [7:0] household_size;
    logic [TCNT_BITS-1:0] target_count;
    logic [TARGETS-1:0][MIN_BITS-1:0] target_minute;
  } cfg_t;

  typedef struct packed {
    logic action;
    logic [MIN_BITS-1:0] minute_of_day;
    logic [DAY_BITS-1:0] day_of_year;
    logic clock_synced;
    logic link_up;
    logic signed [TEMP_BITS-1:0] tank_temp_tenths;
    logic manual_on;
  } item_t;

  typedef struct packed {
    logic heat_request;
    logic history_reliable;
    logic have_history;
    logic [MIN_BITS-1:0] predicted_minute;
    logic [TOTAL_BITS-1:0] days_observed;
    logic [TOTAL_BITS-1:0] total_events;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic take_in;
    logic rd_slot;
    logic wr_slot;
    logic scan_rd;
    logic peak;
    logic dec_clear;
    logic dec_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic record_hit;
    logic is_decide;
    logic scan_last;
    logic dec_last;
  } sts_t;

  function automatic logic [MIN_BITS-1:0] wrap_minute(input logic [MIN_BITS-1:0] m);
    logic [MIN_BITS-1:0] r;
    r = m;
    if (m >= MIN_BITS'(DAY_MIN)) r = m - MIN_BITS'(DAY_MIN);
    return r;
  endfunction

  // Slot of an already wrapped minute, clamped to the last slot.
  function automatic logic [SLOT_BITS-1:0] slot_of(input logic [MIN_BITS-1:0] m);
    logic [PROD_BITS-1:0] prod;
    logic [MIN_BITS-1:0] q;
    prod = PROD_BITS'(m) * PROD_BITS'(SLOT_RECIP);
    q = MIN_BITS'(prod >> RECIP_SHIFT);
    if (q > MIN_BITS'(SLOT_COUNT - 1)) q = MIN_BITS'(SLOT_COUNT - 1);
    return q[SLOT_BITS-1:0];
  endfunction

  // Forward distance on the day circle, both operands below a day.
  function automatic logic [MIN_BITS-1:0] fwd_dist(input logic [MIN_BITS-1:0] from,
                                                    input logic [MIN_BITS-1:0] to);
    logic [MIN_BITS:0] d;
    d = {1'b0, to} + (MIN_BITS+1)'(DAY_MIN) - {1'b0, from};
    if (to >= from) d = {1'b0, to} - {1'b0, from};
    return d[MIN_BITS-1:0];
  endfunction

endpackage

// ===== hw/rtl/lps_if.sv =====
// Channel interfaces of the learned preheat scheduler: item, result, configuration.
// Depends on lps_pkg for field widths.
interface lps_item_if;
  logic valid;
  logic ready;
  logic action;
  logic [lps_pkg::MIN_BITS-1:0] minute_of_day;
  logic [lps_pkg::DAY_BITS-1:0] day_of_year;
  logic clock_synced;
  logic link_up;
  logic signed [lps_pkg::TEMP_BITS-1:0] tank_temp_tenths;
  logic manual_on;
  modport source (output valid, action, minute_of_day, day_of_year, clock_synced, link_up,
                  tank_temp_tenths, manual_on, input ready);
  modport sink (input valid, action, minute_of_day, day_of_year, clock_synced, link_up,
                tank_temp_tenths, manual_on, output ready);
endinterface

interface lps_result_if;
  logic valid;
  logic ready;
  logic heat_request;
  logic history_reliable;
  logic have_history;
  logic [lps_pkg::MIN_BITS-1:0] predicted_minute;
  logic [lps_pkg::TOTAL_BITS-1:0] days_observed;
  logic [lps_pkg::TOTAL_BITS-1:0] total_events;
  modport source (output valid, heat_request, history_reliable, have_history,
                  predicted_minute, days_observed, total_events, input ready);
  modport sink (input valid, heat_request, history_reliable, have_history,
                predicted_minute, days_observed, total_events, output ready);
endinterface

interface lps_cfg_if;
  logic valid;
  logic ready;
  logic [lps_pkg::CFG_IDX_BITS-1:0] index;
  logic [lps_pkg::CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/lps_cfg.sv =====
// Configuration register file of the learned preheat scheduler.
// Depends on lps_pkg for register indexes and the cfg_t type.
module lps_cfg (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  input  logic [lps_pkg::CFG_IDX_BITS-1:0] wr_index,
  input  logic [lps_pkg::CFG_DATA_BITS-1:0] wr_data,
  output logic wr_ready,
  output lps_pkg::cfg_t regs
);

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.operating_mode <= lps_pkg::MODE_IDLE;
      regs.household_size <= 8'd2;
      regs.target_count <= '0;
      regs.target_minute <= '0;
    end else if (wr_valid) begin
      unique case (wr_index)
        lps_pkg::REG_MODE:      regs.operating_mode <= wr_data[1:0];
        lps_pkg::REG_HOUSEHOLD: regs.household_size <= wr_data[7:0];
        lps_pkg::REG_TCOUNT:    regs.target_count <= wr_data[lps_pkg::TCNT_BITS-1:0];
        lps_pkg::REG_TGT_A:     regs.target_minute[0] <= wr_data;
        lps_pkg::REG_TGT_B:     regs.target_minute[1] <= wr_data;
        lps_pkg::REG_TGT_C:     regs.target_minute[2] <= wr_data;
        lps_pkg::REG_TGT_D:     regs.target_minute[3] <= wr_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/lps_ctrl.sv =====
// Sequencing state machine of the learned preheat scheduler.
// Depends on lps_pkg for the command and status structs.
module lps_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  output logic res_valid,
  input  logic res_ready,
  input  lps_pkg::sts_t sts,
  output lps_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_WR    = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_PEAK  = 3'd5;
  localparam logic [2:0] ST_DEC   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic out_free;

  assign item_ready = (state == ST_IDLE);
  assign out_free = !res_valid || res_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.take_in = item_valid;
        if (item_valid) state_next = ST_RD;
      end
      ST_RD: begin
        cmd.rd_slot = sts.record_hit;
        state_next = sts.record_hit ? ST_WR : ST_SCAN;
      end
      ST_WR: begin
        cmd.wr_slot = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_PEAK;
      end
      ST_PEAK: begin
        cmd.peak = 1'b1;
        cmd.dec_clear = sts.is_decide;
        state_next = sts.is_decide ? ST_DEC : ST_OUT;
      end
      ST_DEC: begin
        cmd.dec_step = 1'b1;
        if (sts.dec_last) state_next = ST_OUT;
      end
      ST_OUT: begin
        cmd.load_out = out_free;
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/lps_dp.sv =====
// Datapath of the learned preheat scheduler: slot histogram memory, counters,
// peak scan, heat decision unit and result register. Depends on lps_pkg.
module lps_dp (
  input  logic clk,
  input  logic rst,
  input  lps_pkg::cfg_t regs,
  input  lps_pkg::item_t item_in,
  input  lps_pkg::cmd_t cmd,
  output lps_pkg::sts_t sts,
  output lps_pkg::result_t res
);

  // Histogram memory; an entry never written since reset reads as zero.
  logic [lps_pkg::COUNT_BITS-1:0] mem [lps_pkg::SLOT_COUNT];
  logic [lps_pkg::SLOT_COUNT-1:0] slot_vld;
  logic [lps_pkg::COUNT_BITS-1:0] mem_q;
  logic vld_q;
  logic [lps_pkg::COUNT_BITS-1:0] rd_count;
  logic [lps_pkg::COUNT_BITS-1:0] wr_count;
  logic [lps_pkg::SLOT_BITS-1:0] rd_addr;

  lps_pkg::item_t item;
  logic [lps_pkg::MIN_BITS-1:0] minute;
  logic [lps_pkg::SLOT_BITS-1:0] slot;

  logic [lps_pkg::TOTAL_BITS-1:0] event_total;
  logic [lps_pkg::TOTAL_BITS-1:0] day_total;
  logic [lps_pkg::LAST_DAY_BITS-1:0] last_day;

  logic [lps_pkg::SLOT_BITS-1:0] scan_cnt;
  logic cmp_vld;
  logic [lps_pkg::SLOT_BITS-1:0] cmp_idx;
  logic [lps_pkg::COUNT_BITS-1:0] best_count;
  logic [lps_pkg::SLOT_BITS-1:0] best_slot;

  logic pk_have;
  logic pk_rel;
  logic [lps_pkg::MIN_BITS-1:0] pk_min;

  logic heat;
  logic [lps_pkg::TGT_BITS-1:0] tgt_idx;
  logic [lps_pkg::LEAD_BITS-1:0] lead;
  logic [lps_pkg::TCNT_BITS-1:0] n_tgt;
  logic gate;
  logic [lps_pkg::MIN_BITS-1:0] tgt;
  logic hit;
  logic active;

  assign rd_addr = cmd.scan_rd ? scan_cnt : slot;
  assign rd_count = vld_q ? mem_q : '0;
  assign wr_count = (rd_count == lps_pkg::CNT_MAX) ? rd_count : rd_count + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.wr_slot) mem[slot] <= wr_count;
    if (cmd.rd_slot || cmd.scan_rd) mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
      vld_q <= 1'b0;
    end else begin
      if (cmd.wr_slot) slot_vld[slot] <= 1'b1;
      if (cmd.rd_slot || cmd.scan_rd) vld_q <= slot_vld[rd_addr];
    end
  end

  // Item capture; the slot index comes from the wrapped minute.
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      item <= item_in;
      minute <= lps_pkg::wrap_minute(item_in.minute_of_day);
      slot <= lps_pkg::slot_of(lps_pkg::wrap_minute(item_in.minute_of_day));
    end
  end

  assign sts.record_hit = (item.action == lps_pkg::ACT_RECORD) && item.clock_synced;
  assign sts.is_decide = (item.action == lps_pkg::ACT_DECIDE);
  assign sts.scan_last = (scan_cnt == lps_pkg::SLOT_BITS'(lps_pkg::SLOT_COUNT - 1));
  assign sts.dec_last = (tgt_idx == lps_pkg::TGT_BITS'(lps_pkg::TARGETS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      event_total <= '0;
      day_total <= '0;
      last_day <= lps_pkg::NO_DAY;
    end else if (cmd.wr_slot) begin
      if (event_total != lps_pkg::SAT16) event_total <= event_total + 1'b1;
      if ({1'b0, item.day_of_year} != last_day) begin
        if (day_total != lps_pkg::SAT16) day_total <= day_total + 1'b1;
        last_day <= {1'b0, item.day_of_year};
      end
    end
  end

  // Peak scan: one slot read per cycle, compared in the cycle after its read.
  // A strict compare keeps the lowest slot among equal maxima.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_cnt;
    if (cmd.take_in) begin
      scan_cnt <= '0;
      best_count <= '0;
      best_slot <= '0;
    end else begin
      if (cmd.scan_rd && !sts.scan_last) scan_cnt <= scan_cnt + 1'b1;
      if (cmp_vld && (rd_count > best_count)) begin
        best_count <= rd_count;
        best_slot <= cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.peak) begin
      pk_have <= (best_count != '0);
      pk_rel <= (best_count != '0) &&
                (best_count >= lps_pkg::COUNT_BITS'(lps_pkg::REL_COUNT)) &&
                (day_total >= lps_pkg::TOTAL_BITS'(lps_pkg::REL_DAYS));
      if (best_count != '0) begin
        pk_min <= lps_pkg::MIN_BITS'(best_slot) * lps_pkg::MIN_BITS'(lps_pkg::SLOT_W)
                  + lps_pkg::MIN_BITS'(lps_pkg::SLOT_W / 2);
      end else begin
        pk_min <= '0;
      end
    end
  end

  // Lead grows by a fixed step per person above two, up to a cap.
  always_comb begin
    if (regs.household_size >= 8'(lps_pkg::LEAD_CAP_SIZE)) begin
      lead = lps_pkg::LEAD_BITS'(lps_pkg::LEAD_MAX);
    end else if (regs.household_size > 8'(lps_pkg::LEAD_FREE_SIZE)) begin
      lead = lps_pkg::LEAD_BITS'(lps_pkg::LEAD_BASE) + lps_pkg::LEAD_BITS'(lps_pkg::LEAD_STEP)
             * (lps_pkg::LEAD_BITS'(regs.household_size)
                - lps_pkg::LEAD_BITS'(lps_pkg::LEAD_FREE_SIZE));
    end else begin
      lead = lps_pkg::LEAD_BITS'(lps_pkg::LEAD_BASE);
    end
  end

  always_comb begin
    case (regs.operating_mode)
      lps_pkg::MODE_READY_BY: begin
        n_tgt = (regs.target_count > lps_pkg::TCNT_BITS'(lps_pkg::TARGETS))
                ? lps_pkg::TCNT_BITS'(lps_pkg::TARGETS) : regs.target_count;
      end
      lps_pkg::MODE_SMART: n_tgt = pk_rel ? lps_pkg::TCNT_BITS'(1) : '0;
      default: n_tgt = '0;
    endcase
  end

  assign gate = item.link_up && item.clock_synced && !item.manual_on &&
                (item.tank_temp_tenths < lps_pkg::HOT_LIMIT);
  assign tgt = (regs.operating_mode == lps_pkg::MODE_SMART) ? pk_min
               : lps_pkg::wrap_minute(regs.target_minute[tgt_idx]);
  assign hit = (lps_pkg::fwd_dist(minute, tgt) <= lps_pkg::MIN_BITS'(lead)) ||
               (lps_pkg::fwd_dist(tgt, minute) <= lps_pkg::MIN_BITS'(lps_pkg::GRACE_MIN));
  assign active = gate && (lps_pkg::TCNT_BITS'(tgt_idx) < n_tgt);

  // Heat decision: one target checked per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      heat <= 1'b0;
    end else if (cmd.dec_clear) begin
      heat <= 1'b0;
    end else if (cmd.dec_step && active && hit) begin
      heat <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      tgt_idx <= '0;
    end else if (cmd.dec_step && !sts.dec_last) begin
      tgt_idx <= tgt_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res.heat_request <= heat;
      res.history_reliable <= pk_rel;
      res.have_history <= pk_have;
      res.predicted_minute <= pk_min;
      res.days_observed <= day_total;
      res.total_events <= event_total;
    end
  end

  // A new day is only counted together with a recorded shower.
  a_days_le_events: assert property (@(posedge clk) disable iff (rst)
    day_total <= event_total)
    else $error("day count exceeds event count");

  a_events_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> event_total >= $past(event_total))
    else $error("event total decreased");

  a_scan_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.take_in |=> (best_count == '0) && (scan_cnt == '0))
    else $error("peak scan not restarted for a new request");

  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_slot && (cmd.scan_rd || cmd.rd_slot)))
    else $error("histogram write overlaps a read");

  a_heat_gated: assert property (@(posedge clk) disable iff (rst)
    (cmd.dec_step && !gate) |=> !heat)
    else $error("heat requested with the decision gate closed");

endmodule

// ===== hw/rtl/learned_preheat_scheduler.sv =====
// Learned preheat scheduler top level.
// Channels: item (sink) carries record and decide requests, result (source) returns
// one result per request, cfg (sink) writes the seven configuration registers.
// Every channel moves a request at a rising edge where valid and ready are both high.
// One request is in work at a time. After acceptance the block reads the slot
// histogram one entry per cycle through the single read port of the 96-entry
// histogram memory to find the peak; a synced record request first reads and
// increments the count of its slot, and a decide request then checks the targets.
// The next request is taken in the cycle after the result is loaded.
// The result register holds its value while the receiver stalls; a new request is
// accepted meanwhile, and its result waits until the previous one is taken.
// Reset (rst, synchronous, active high) clears the histogram through per-slot valid
// bits, zeroes the event and day counters and the heat request, and loads register
// defaults; the block accepts requests in the cycle after reset. Configuration
// writes are always ready and should be issued only while no request is in work.
// Depends on lps_pkg, lps_if, lps_cfg, lps_ctrl and lps_dp.
module learned_preheat_scheduler (
  input logic clk,
  input logic rst,
  lps_item_if.sink item,
  lps_result_if.source result,
  lps_cfg_if.sink cfg
);

  lps_pkg::cfg_t regs;
  lps_pkg::cmd_t cmd;
  lps_pkg::sts_t sts;
  lps_pkg::item_t item_in;
  lps_pkg::result_t res;

  assign item_in.action = item.action;
  assign item_in.minute_of_day = item.minute_of_day;
  assign item_in.day_of_year = item.day_of_year;
  assign item_in.clock_synced = item.clock_synced;
  assign item_in.link_up = item.link_up;
  assign item_in.tank_temp_tenths = item.tank_temp_tenths;
  assign item_in.manual_on = item.manual_on;

  lps_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .wr_ready (cfg.ready),
    .regs     (regs)
  );

  lps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lps_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .item_in (item_in),
    .cmd     (cmd),
    .sts     (sts),
    .res     (res)
  );

  assign result.heat_request = res.heat_request;
  assign result.history_reliable = res.history_reliable;
  assign result.have_history = res.have_history;
  assign result.predicted_minute = res.predicted_minute;
  assign result.days_observed = res.days_observed;
  assign result.total_events = res.total_events;

endmodule
